// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the display driver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MSBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define MSBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/msbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display driver package
// Types, constants and the segment pattern table of the display driver.
// ----------------------------------------------------------------------------
package msbd_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int SCAN_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int NUM_W      = 32;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int EL_W       = 17;
  localparam int PER_W      = 16;
  localparam int LINES_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [EL_W-1:0] EL_MAX = {EL_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS      = 1'd1;

  typedef enum logic [1:0] {
    OP_SHOW   = 2'd0,
    OP_BLINK  = 2'd1,
    OP_STEADY = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    op_e         opcode;
    logic [31:0] number;
    logic [7:0]  digit_index;
    logic [15:0] blink_ms;
  } in_item_t;

  typedef struct packed {
    logic       error;
    logic       drive_valid;
    logic [3:0] digit_lines;
    logic [7:0] segment_lines;
  } out_item_t;

  // Segment patterns, bit 7 is segment A down to bit 1 for G, bit 0 is DP.
  function automatic logic [7:0] seg_pattern(input logic [3:0] v);
    logic [7:0] p;
    case (v)
      4'd0:    p = 8'hFC;
      4'd1:    p = 8'h60;
      4'd2:    p = 8'hDA;
      4'd3:    p = 8'hF2;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'hB6;
      4'd6:    p = 8'hBE;
      4'd7:    p = 8'hE0;
      4'd8:    p = 8'hFE;
      4'd9:    p = 8'hF6;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/muxed_seven_segment_blink_driver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiplexed seven-segment blink driver
// Decimal display controller with per-digit blinking and scan multiplexing.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_valid_i/in_stall_o and every item gives exactly one
// result on out_valid_o/out_stall_i. A show item converts its number to
// decimal with a shift-and-add-3 converter that takes one input bit per
// cycle, and in_stall_o stays high through the conversion until its result
// is loaded into the output register. Blink, steady and tick items skip
// the conversion and wait in staging until the output register is free.
// A new item is accepted once the previous one has moved its result into
// the output register; the output register decouples the two sides, so
// the block takes the next item while a result waits. If the receiver
// stalls, the result holds in the output register, the next result waits
// in staging, and in_stall_o stays high until it can move on.
// Tick results carry the pin levels of the scanned digit and advance the
// scan. Reset shows all zeros, lit and steady, scan at digit 0, active
// level 0 and one millisecond per tick. Configuration writes take effect
// at once and are meant to be made while the block is idle.
module muxed_seven_segment_blink_driver (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  msbd_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output msbd_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [msbd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [msbd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import msbd_pkg::*;

  `include "assert_macros.svh"

  state_e state_q, state_d;

  logic             active_level_q;
  logic [7:0]       tick_ms_q;

  logic [3:0]       digit_q    [NUM_DIGITS];
  logic             lit_q      [NUM_DIGITS];
  logic             blinking_q [NUM_DIGITS];
  logic [PER_W-1:0] period_q   [NUM_DIGITS];
  logic [EL_W-1:0]  elapsed_q  [NUM_DIGITS];
  logic [SCAN_W-1:0] scan_q;

  logic [NUM_W-1:0] num_q;
  logic [BCD_W-1:0] bcd_q, bcd_adj, bcd_d;
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic             carry;

  out_item_t        res_q, tick_res;
  out_item_t        out_q;
  logic             out_valid_q;

  logic             in_acc, slot_free, load_out;
  logic             idx_ok;
  logic [SCAN_W-1:0] idx;

  logic             lit_upd [NUM_DIGITS];
  logic [EL_W-1:0]  el_upd  [NUM_DIGITS];

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == ST_DONE) && slot_free;
  assign idx_ok    = ({24'd0, in_item_i.digit_index} < 32'(NUM_DIGITS));
  assign idx       = in_item_i.digit_index[SCAN_W-1:0];

  // One shift-and-add-3 step: digits of 5 or more get 3 added before the
  // doubling, and a bit leaving the top digit marks an overflow.
  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
    bcd_d = {bcd_adj[BCD_W-2:0], num_q[NUM_W-1]};
    carry = bcd_adj[BCD_W-1];
  end

  // Blink counters of all digits for a tick.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      logic [EL_W-1:0] e0;
      logic [EL_W:0]   sum;
      lit_upd[i] = lit_q[i];
      el_upd[i]  = elapsed_q[i];
      e0         = elapsed_q[i];
      if (elapsed_q[i] >= {1'b0, period_q[i]}) begin
        lit_upd[i] = !lit_q[i];
        e0         = '0;
      end
      sum = {1'b0, e0} + (EL_W + 1)'(tick_ms_q);
      if (blinking_q[i]) begin
        el_upd[i] = sum[EL_W] ? EL_MAX : sum[EL_W-1:0];
      end else begin
        lit_upd[i] = lit_q[i];
      end
    end
  end

  // Pin levels of the scanned digit after the blink update.
  always_comb begin
    logic [7:0] off;
    logic       on;
    off = {8{active_level_q}};
    on  = lit_upd[scan_q];
    tick_res             = '0;
    tick_res.drive_valid = 1'b1;
    for (int i = 0; i < LINES_W; i++) begin
      if (i < NUM_DIGITS) begin
        if (on && (scan_q == SCAN_W'(i))) begin
          tick_res.digit_lines[i] = active_level_q;
        end else begin
          tick_res.digit_lines[i] = !active_level_q;
        end
      end
    end
    tick_res.segment_lines = on ? (seg_pattern(digit_q[scan_q]) ^ off) : off;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_item_i.opcode == OP_SHOW) ? ST_CONV : ST_DONE;
        end
      end
      ST_CONV: begin
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      active_level_q <= 1'b0;
      tick_ms_q      <= 8'd1;
      scan_q         <= '0;
      out_valid_q    <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_q[i]    <= '0;
        lit_q[i]      <= 1'b1;
        blinking_q[i] <= 1'b0;
        period_q[i]   <= '0;
        elapsed_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ACTIVE_LEVEL: active_level_q <= cfg_data_i[0];
          CFG_TICK_MS:      tick_ms_q      <= cfg_data_i;
          default:          ;
        endcase
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc) begin
        case (in_item_i.opcode)
          OP_BLINK: begin
            if (idx_ok) begin
              blinking_q[idx] <= 1'b1;
              period_q[idx]   <= in_item_i.blink_ms;
              elapsed_q[idx]  <= '0;
            end
          end
          OP_STEADY: begin
            if (idx_ok) begin
              blinking_q[idx] <= 1'b0;
              lit_q[idx]      <= 1'b1;
            end
          end
          OP_TICK: begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
              lit_q[i]     <= lit_upd[i];
              elapsed_q[i] <= el_upd[i];
            end
            if (scan_q == SCAN_W'(NUM_DIGITS - 1)) begin
              scan_q <= '0;
            end else begin
              scan_q <= scan_q + 1'b1;
            end
          end
          default: ;
        endcase
      end

      // The least significant decimal digit lands at the highest index.
      if ((state_q == ST_CONV) && (cnt_q == CNT_W'(NUM_W - 1))) begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
          digit_q[NUM_DIGITS-1-k] <= bcd_d[4*k +: 4];
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      num_q <= in_item_i.number;
      bcd_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      case (in_item_i.opcode)
        OP_BLINK, OP_STEADY: begin
          res_q <= '{error: !idx_ok, drive_valid: 1'b0, digit_lines: 4'd0,
                     segment_lines: 8'd0};
        end
        OP_TICK:             res_q <= tick_res;
        default:             res_q <= '0;
      endcase
    end else if (state_q == ST_CONV) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      bcd_q <= bcd_d;
      cnt_q <= cnt_q + 1'b1;
      ovf_q <= ovf_q | carry;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        res_q.error <= ovf_q | carry;
      end
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MSBD_ASSERT_NEXT(a_show_converts, clk_i, rst_ni,
      in_acc && (in_item_i.opcode == OP_SHOW), state_q == ST_CONV,
      "accepted show item did not start the conversion")
  `MSBD_ASSERT_IMP(a_plain_no_pins, clk_i, rst_ni,
      out_valid_o && !out_item_o.drive_valid,
      (out_item_o.digit_lines == 4'd0) && (out_item_o.segment_lines == 8'd0),
      "non-tick result drives pin levels")
  `MSBD_ASSERT_IMP(a_tick_no_error, clk_i, rst_ni,
      out_valid_o && out_item_o.drive_valid, !out_item_o.error,
      "tick result flags an error")
  `MSBD_ASSERT_IMP(a_one_digit_on, clk_i, rst_ni,
      out_valid_o && out_item_o.drive_valid,
      $onehot0(out_item_o.digit_lines ^ {LINES_W{!active_level_q}}),
      "more than one digit line is active")

endmodule
